// ===== src/atfb_pkg.sv =====
`timescale 1ns / 1ps

package atfb_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned StepW    = 5;

  localparam logic [ByteW-1:0] MaxPayload  = 8'd241;
  localparam logic [ByteW-1:0] LenOffset   = 8'd14;
  localparam logic [ByteW-1:0] ByteZero    = 8'h00;
  localparam logic [ByteW-1:0] ByteFf      = 8'hFF;
  localparam logic [ByteW-1:0] ByteFe      = 8'hFE;

  localparam logic [AddrW-1:0] DestAddrRst   = 64'd0;
  localparam logic [ByteW-1:0] StartDelimRst = 8'h7E;
  localparam logic [ByteW-1:0] FrameTypeRst  = 8'h10;

  localparam logic [CfgIdxW-1:0] RegDestAddr   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStartDelim = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameType  = 2'd2;

  // position of the byte within one frame
  localparam logic [StepW-1:0] StepDelim     = 5'd0;
  localparam logic [StepW-1:0] StepLenHi     = 5'd1;
  localparam logic [StepW-1:0] StepLenLo     = 5'd2;
  localparam logic [StepW-1:0] StepType      = 5'd3;
  localparam logic [StepW-1:0] StepFrameId   = 5'd4;
  localparam logic [StepW-1:0] StepAddrFirst = 5'd5;
  localparam logic [StepW-1:0] StepAddrLast  = 5'd12;
  localparam logic [StepW-1:0] StepNetHi     = 5'd13;
  localparam logic [StepW-1:0] StepNetLo     = 5'd14;
  localparam logic [StepW-1:0] StepRadius    = 5'd15;
  localparam logic [StepW-1:0] StepOptions   = 5'd16;
  localparam logic [StepW-1:0] StepPayload   = 5'd17;
  localparam logic [StepW-1:0] StepChecksum  = 5'd18;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] len;
    logic             first;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [AddrW-1:0] dest_addr;
    logic [ByteW-1:0] start_delim;
    logic [ByteW-1:0] frame_type;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== src/atfb_front.sv =====
`timescale 1ns / 1ps

module atfb_front import atfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic [ByteW-1:0] payload_length_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output entry_t           q_entry_o
);

  logic [ByteW-1:0] bytes_left_q, bytes_left_d;
  logic [ByteW-1:0] len_sat;
  logic [ByteW-1:0] count;
  logic             first;

  always_comb begin
    if (payload_length_i == ByteZero) begin
      len_sat = 8'd1;
    end else if (payload_length_i > MaxPayload) begin
      len_sat = MaxPayload;
    end else begin
      len_sat = payload_length_i;
    end
  end

  assign first      = (bytes_left_q == ByteZero);
  assign count      = first ? len_sat : bytes_left_q;
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  assign q_entry_o.data  = payload_byte_i;
  assign q_entry_o.len   = len_sat;
  assign q_entry_o.first = first;
  assign q_entry_o.last  = (count == 8'd1);

  assign bytes_left_d = q_push_o ? count - 8'd1 : bytes_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

// ===== src/atfb_queue.sv =====
`timescale 1ns / 1ps

module atfb_queue import atfb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_entry_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.valid = (count_q != 2'd0);

  assign wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== src/atfb_back.sv =====
`timescale 1ns / 1ps

module atfb_back import atfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             head_valid_i,
  input  entry_t           head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] frame_byte_o,
  output logic             frame_end_o
);

  logic [StepW-1:0] step_q, step_d;
  logic [StepW-1:0] eff;
  logic [StepW-1:0] addr_sel;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] byte_nxt;
  logic             emit;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] frame_byte_q;
  logic             frame_end_q;

  assign eff      = head_i.first ? step_q : step_q + StepPayload;
  assign addr_sel = StepAddrLast - eff;
  assign emit     = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = emit && ((eff == StepPayload && !head_i.last) || eff == StepChecksum);

  always_comb begin
    unique case (eff)
      StepDelim:   byte_nxt = cfg_i.start_delim;
      StepLenHi:   byte_nxt = ByteZero;
      StepLenLo:   byte_nxt = head_i.len + LenOffset;
      StepType:    byte_nxt = cfg_i.frame_type;
      StepFrameId: byte_nxt = ByteZero;
      StepNetHi:   byte_nxt = ByteFf;
      StepNetLo:   byte_nxt = ByteFe;
      StepRadius:  byte_nxt = ByteZero;
      StepOptions: byte_nxt = ByteZero;
      StepPayload: byte_nxt = head_i.data;
      StepChecksum: byte_nxt = ~sum_q;
      default:     byte_nxt = cfg_i.dest_addr[ByteW*addr_sel[2:0] +: ByteW];
    endcase
  end

  always_comb begin
    step_d = step_q;
    sum_d  = sum_q;
    if (emit) begin
      step_d = pop_o ? '0 : step_q + 5'd1;
      if (eff == StepType) begin
        sum_d = byte_nxt;
      end else if (eff > StepType && eff <= StepPayload) begin
        sum_d = sum_q + byte_nxt;
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_byte_q <= byte_nxt;
      frame_end_q  <= (eff == StepChecksum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign frame_end_o  = frame_end_q;

endmodule

// ===== src/api_transmit_frame_builder.sv =====
`timescale 1ns / 1ps
// A payload byte passes a queue entry and the output register, and leaves behind any header
// bytes; the first byte of a frame is preceded by 17 header bytes. The output sequencer sends
// one byte per cycle while out_ready_i is high and the queue holds an entry; a frame of N
// payload bytes is N + 18 bytes; mid-frame bytes enter one per cycle while the queue has room.
// Reset: asynchronous, active low; clears the queue, the frame counter and the checksum.
module api_transmit_frame_builder import atfb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   payload_byte_i,
  input  logic [ByteW-1:0]   payload_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   frame_byte_o,
  output logic               frame_end_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  logic      cfg_we;
  logic      q_push;
  logic      q_pop;
  entry_t    q_in;
  entry_t    q_head;
  q_status_t q_stat;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        RegDestAddr:   cfg_d.dest_addr   = cfg_data_i;
        RegStartDelim: cfg_d.start_delim = cfg_data_i[ByteW-1:0];
        RegFrameType:  cfg_d.frame_type  = cfg_data_i[ByteW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_addr   <= DestAddrRst;
      cfg_q.start_delim <= StartDelimRst;
      cfg_q.frame_type  <= FrameTypeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  atfb_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .q_full_i         (q_stat.full),
    .q_push_o         (q_push),
    .q_entry_o        (q_in)
  );

  atfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .status_o     (q_stat)
  );

  atfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_stat.valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_stat.valid)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_end_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && q_head.last) |=> (out_valid_o && frame_end_o))
    else $error("last entry left the queue without a checksum byte");

  a_cfg_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && cfg_index_i == RegDestAddr) |=> (cfg_q.dest_addr == $past(cfg_data_i)))
    else $error("destination write lost");
`endif

endmodule
